// File: design/sdbr_pkg.sv
// Shared types and constants for the SD card SPI single block read core.
// Used by the sequencing engine and the top level.
package sdbr_pkg;

    localparam logic [7:0] CMD_PREFIX     = 8'h40;
    localparam logic [7:0] CMD_READ_BLOCK = 8'd17;
    localparam logic [7:0] FRAME_END      = 8'h01;
    localparam logic [7:0] TOKEN_START    = 8'hFE;
    localparam logic [7:0] FILL_BYTE      = 8'hFF;
    localparam logic [7:0] R1_BUSY_MASK   = 8'h80;

    localparam logic [7:0] POLL_LIMIT      = 8'd255;
    localparam logic [9:0] MAX_BLOCK_BYTES = 10'd512;
    localparam logic [2:0] FRAME_LAST      = 3'd5;

    localparam logic OP_START    = 1'b0;
    localparam logic OP_EXCHANGE = 1'b1;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_SPI_ERROR     = 3'd1;
    localparam logic [2:0] ST_R1_TIMEOUT    = 3'd2;
    localparam logic [2:0] ST_TOKEN_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_BAD_R1        = 3'd4;
    localparam logic [2:0] ST_BAD_TOKEN     = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_CMD   = 3'd1,
        PH_R1    = 3'd2,
        PH_TOKEN = 3'd3,
        PH_DATA  = 3'd4,
        PH_CRC   = 3'd5
    } t_phase;

    typedef struct packed {
        logic        op;
        logic [31:0] blk_num;
        logic [9:0]  byte_count;
        logic [7:0]  rx_byte;
        logic        xfer_err;
    } t_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       send_request;
        logic       chip_select_active;
        logic [7:0] data_byte;
        logic       data_valid;
        logic       done_res;
        logic [2:0] status;
    } t_result;

endpackage

// File: design/sdbr_in_if.sv
// Request channel into the block read core: valid/ready handshake plus one item.
// Stands alone; widths follow the item fields.
interface sdbr_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] blk_num;
    logic [9:0]  byte_count;
    logic [7:0]  rx_byte;
    logic        xfer_err;

    modport source (output valid, op, blk_num, byte_count, rx_byte, xfer_err,
                    input ready);
    modport sink   (input valid, op, blk_num, byte_count, rx_byte, xfer_err,
                    output ready);
endinterface

// File: design/sdbr_out_if.sv
// Result channel out of the block read core: valid/ready handshake plus one result.
// Stands alone; widths follow the result fields.
interface sdbr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       send_request;
    logic       chip_select_active;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       done_res;
    logic [2:0] status;

    modport source (output valid, tx_byte, send_request, chip_select_active, data_byte,
                    data_valid, done_res, status, input ready);
    modport sink   (input valid, tx_byte, send_request, chip_select_active, data_byte,
                    data_valid, done_res, status, output ready);
endinterface

// File: design/sdbr_engine.sv
// Transaction state and per-request decision logic of the CMD17 read sequence.
// Depends on sdbr_pkg for the phase type, item and result structs and constants.
module sdbr_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  sdbr_pkg::t_item   i_item,
    input  logic [3:0]        i_addr_shift,
    output sdbr_pkg::t_result o_res
);

    sdbr_pkg::t_phase r_phase, n_phase;
    logic [31:0]      r_arg, n_arg;
    logic [2:0]       r_frame, n_frame;
    logic [7:0]       r_poll, n_poll;
    logic [9:0]       r_data, n_data;
    logic [9:0]       r_wanted, n_wanted;

    logic       poll_timeout;
    logic       data_last;
    logic [7:0] rx;
    logic [7:0] next_frame_byte;

    function automatic logic [7:0] frame_byte(input logic [2:0] idx, input logic [31:0] arg);
        logic [7:0] b;
        case (idx)
            3'd0:    b = sdbr_pkg::CMD_PREFIX | sdbr_pkg::CMD_READ_BLOCK;
            3'd1:    b = arg[31:24];
            3'd2:    b = arg[23:16];
            3'd3:    b = arg[15:8];
            3'd4:    b = arg[7:0];
            default: b = sdbr_pkg::FRAME_END;
        endcase
        return b;
    endfunction

    assign rx = i_item.rx_byte;
    // The poll window is POLL_LIMIT+1 exchanges, so the last one ends it.
    assign poll_timeout    = (r_poll == sdbr_pkg::POLL_LIMIT);
    assign data_last       = ({1'b0, r_data} + 11'd1) >= {1'b0, r_wanted};
    assign next_frame_byte = frame_byte(r_frame + 3'd1, r_arg);

    always_comb begin
        n_phase  = r_phase;
        n_arg    = r_arg;
        n_frame  = r_frame;
        n_poll   = r_poll;
        n_data   = r_data;
        n_wanted = r_wanted;
        if (i_fire) begin
            if (i_item.op == sdbr_pkg::OP_START) begin
                n_arg    = i_item.blk_num << i_addr_shift;
                n_wanted = (i_item.byte_count > sdbr_pkg::MAX_BLOCK_BYTES) ?
                           sdbr_pkg::MAX_BLOCK_BYTES : i_item.byte_count;
                n_frame  = '0;
                n_poll   = '0;
                n_data   = '0;
                n_phase  = sdbr_pkg::PH_CMD;
            end else if (r_phase != sdbr_pkg::PH_IDLE) begin
                if (i_item.xfer_err) begin
                    n_phase = sdbr_pkg::PH_IDLE;
                end else begin
                    case (r_phase)
                        sdbr_pkg::PH_CMD: begin
                            if (r_frame < sdbr_pkg::FRAME_LAST) begin
                                n_frame = r_frame + 3'd1;
                            end else begin
                                n_phase = sdbr_pkg::PH_R1;
                                n_poll  = '0;
                            end
                        end
                        sdbr_pkg::PH_R1: begin
                            n_poll = r_poll + 8'd1;
                            if (poll_timeout) begin
                                n_phase = sdbr_pkg::PH_IDLE;
                            end else if ((rx & sdbr_pkg::R1_BUSY_MASK) == 8'd0) begin
                                if (rx != 8'd0) begin
                                    n_phase = sdbr_pkg::PH_IDLE;
                                end else begin
                                    n_phase = sdbr_pkg::PH_TOKEN;
                                    n_poll  = '0;
                                end
                            end
                        end
                        sdbr_pkg::PH_TOKEN: begin
                            n_poll = r_poll + 8'd1;
                            if (poll_timeout) begin
                                n_phase = sdbr_pkg::PH_IDLE;
                            end else if (rx != sdbr_pkg::FILL_BYTE) begin
                                if (rx != sdbr_pkg::TOKEN_START) begin
                                    n_phase = sdbr_pkg::PH_IDLE;
                                end else begin
                                    n_data  = '0;
                                    n_frame = '0;
                                    n_phase = (r_wanted == 10'd0) ? sdbr_pkg::PH_CRC
                                                                  : sdbr_pkg::PH_DATA;
                                end
                            end
                        end
                        sdbr_pkg::PH_DATA: begin
                            n_data = r_data + 10'd1;
                            if (data_last) begin
                                n_phase = sdbr_pkg::PH_CRC;
                                n_frame = '0;
                            end
                        end
                        sdbr_pkg::PH_CRC: begin
                            if (r_frame == 3'd0) begin
                                n_frame = 3'd1;
                            end else begin
                                n_phase = sdbr_pkg::PH_IDLE;
                            end
                        end
                        default: begin
                            n_phase = sdbr_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
        end
    end

    // Result of the current request; a finishing request drops chip select.
    always_comb begin
        o_res                    = '0;
        o_res.tx_byte            = sdbr_pkg::FILL_BYTE;
        o_res.send_request       = 1'b1;
        o_res.chip_select_active = 1'b1;
        if (i_item.op == sdbr_pkg::OP_START) begin
            o_res.tx_byte = frame_byte(3'd0, r_arg);
        end else if (r_phase == sdbr_pkg::PH_IDLE) begin
            o_res.send_request       = 1'b0;
            o_res.chip_select_active = 1'b0;
        end else if (i_item.xfer_err) begin
            o_res.send_request       = 1'b0;
            o_res.chip_select_active = 1'b0;
            o_res.done_res           = 1'b1;
            o_res.status             = sdbr_pkg::ST_SPI_ERROR;
        end else begin
            case (r_phase)
                sdbr_pkg::PH_CMD: begin
                    if (r_frame < sdbr_pkg::FRAME_LAST) begin
                        o_res.tx_byte = next_frame_byte;
                    end
                end
                sdbr_pkg::PH_R1: begin
                    if (poll_timeout) begin
                        o_res.done_res = 1'b1;
                        o_res.status   = sdbr_pkg::ST_R1_TIMEOUT;
                    end else if ((rx & sdbr_pkg::R1_BUSY_MASK) == 8'd0 && rx != 8'd0) begin
                        o_res.done_res = 1'b1;
                        o_res.status   = sdbr_pkg::ST_BAD_R1;
                    end
                end
                sdbr_pkg::PH_TOKEN: begin
                    if (poll_timeout) begin
                        o_res.done_res = 1'b1;
                        o_res.status   = sdbr_pkg::ST_TOKEN_TIMEOUT;
                    end else if (rx != sdbr_pkg::FILL_BYTE && rx != sdbr_pkg::TOKEN_START) begin
                        o_res.done_res = 1'b1;
                        o_res.status   = sdbr_pkg::ST_BAD_TOKEN;
                    end
                end
                sdbr_pkg::PH_DATA: begin
                    o_res.data_byte  = rx;
                    o_res.data_valid = 1'b1;
                end
                sdbr_pkg::PH_CRC: begin
                    if (r_frame != 3'd0) begin
                        o_res.done_res = 1'b1;
                        o_res.status   = sdbr_pkg::ST_OK;
                    end
                end
                default: begin
                    o_res.done_res = 1'b1;
                end
            endcase
            if (o_res.done_res) begin
                o_res.send_request       = 1'b0;
                o_res.chip_select_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= sdbr_pkg::PH_IDLE;
            r_arg    <= '0;
            r_frame  <= '0;
            r_poll   <= '0;
            r_data   <= '0;
            r_wanted <= '0;
        end else begin
            r_phase  <= n_phase;
            r_arg    <= n_arg;
            r_frame  <= n_frame;
            r_poll   <= n_poll;
            r_data   <= n_data;
            r_wanted <= n_wanted;
        end
    end

endmodule

// File: design/sd_spi_block_read_core.sv
// SD card SPI mode single block read (CMD17) sequencing core.
// Depends on sdbr_pkg, sdbr_in_if, sdbr_out_if and sdbr_engine.
//
// Usage: each request on i_in is either a start (block number and byte count)
// or the report of one finished SPI byte exchange (received byte and an error
// flag). For every request the core returns exactly one result on o_out: the
// next byte to shift out, whether to run another exchange, the chip select
// level, a captured data byte when one is present, and on the final result of
// a read the done flag and a status code.
// A request passes through the request register, then the result register.
// A request can be taken every cycle while o_out does not stall; the
// decision logic between the two registers is a single pass over the
// transaction state.
// When o_out stalls, the result register holds and the request register
// still takes one more request; i_in.ready falls only when both are full.
// The user must write the address shift register (i_cfg_we, i_cfg_data) only
// while no read is in flight; the core does not enforce this. It scales the
// block number into the command argument. Synchronous reset clears the pipeline,
// the address shift and the transaction state to idle; no clearing pass is needed.
module sd_spi_block_read_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [3:0]   i_cfg_data,
    sdbr_in_if.sink      i_in,
    sdbr_out_if.source   o_out
);

    logic              r_s1_valid;
    sdbr_pkg::t_item   r_s1_item;
    logic              r_s2_valid;
    sdbr_pkg::t_result r_s2_res;
    logic [3:0]        r_addr_shift;

    sdbr_pkg::t_result step_res;
    logic              s2_free;
    logic              advance;
    logic              in_take;

    assign s2_free = !r_s2_valid || o_out.ready;
    assign advance = r_s1_valid && s2_free;
    assign i_in.ready = !r_s1_valid || advance;
    assign in_take = i_in.valid && i_in.ready;

    sdbr_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (advance),
        .i_item       (r_s1_item),
        .i_addr_shift (r_addr_shift),
        .o_res        (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_addr_shift <= '0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_s2_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_s2_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_addr_shift <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_item.op         <= i_in.op;
            r_s1_item.blk_num    <= i_in.blk_num;
            r_s1_item.byte_count <= i_in.byte_count;
            r_s1_item.rx_byte    <= i_in.rx_byte;
            r_s1_item.xfer_err   <= i_in.xfer_err;
        end
        if (advance) begin
            r_s2_res <= step_res;
        end
    end

    assign o_out.valid              = r_s2_valid;
    assign o_out.tx_byte            = r_s2_res.tx_byte;
    assign o_out.send_request       = r_s2_res.send_request;
    assign o_out.chip_select_active = r_s2_res.chip_select_active;
    assign o_out.data_byte          = r_s2_res.data_byte;
    assign o_out.data_valid         = r_s2_res.data_valid;
    assign o_out.done_res           = r_s2_res.done_res;
    assign o_out.status             = r_s2_res.status;

    // A waiting request is never dropped while the result side is stalled.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s2_free |=> r_s1_valid)
        else $error("pending request lost during stall");

    // A final result always releases the card and asks for no further exchange.
    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && step_res.done_res |-> !step_res.send_request
                                          && !step_res.chip_select_active)
        else $error("final result keeps the card selected");

    // Data bytes only appear within an active read and never carry an error.
    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && step_res.data_valid |-> step_res.chip_select_active
                                           && !step_res.done_res
                                           && step_res.status == sdbr_pkg::ST_OK)
        else $error("data byte outside an active read");

    // A stored result reaches the output on the next cycle.
    a_s2_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_s2_valid)
        else $error("result register failed to load");

endmodule
